/* design/gbc_pkg.sv */
// Shared types, S-box table and round function for the GOST block cipher core.
package gbc_pkg;

    localparam int NumRounds = 32;
    localparam int MacRounds = 16;
    localparam int EncFwdRounds = 24;
    localparam int NumKeys = 8;
    localparam int HalfW = 32;
    localparam int RotAmt = 11;

    typedef enum logic [1:0] {
        REG_KEY01 = 2'd0,
        REG_KEY23 = 2'd1,
        REG_KEY45 = 2'd2,
        REG_KEY67 = 2'd3
    } t_reg_idx;

    localparam logic KIND_ENC = 1'b0;
    localparam logic KIND_MAC = 1'b1;

    typedef logic [NumKeys-1:0][HalfW-1:0] t_key_words;

    // u is the half about to be swapped out, v the half fed to the round function
    typedef struct packed {
        logic             valid;
        logic             kind;
        logic [HalfW-1:0] u;
        logic [HalfW-1:0] v;
    } t_stage;

    localparam logic [7:0] SBOX [64] = '{
        8'hc4, 8'hed, 8'h83, 8'hc9, 8'h92, 8'h98, 8'hfe, 8'h6b,
        8'hff, 8'hbe, 8'h65, 8'h5c, 8'he5, 8'h2c, 8'hb9, 8'h20,
        8'h89, 8'h57, 8'h16, 8'hb3, 8'h11, 8'hf3, 8'h98, 8'h06,
        8'h30, 8'h79, 8'hc0, 8'h97, 8'ha8, 8'h1a, 8'h5d, 8'hd5,
        8'h2e, 8'h01, 8'hda, 8'h34, 8'h73, 8'hd5, 8'h3b, 8'he8,
        8'h4b, 8'hc2, 8'h77, 8'h7e, 8'hdc, 8'h64, 8'hac, 8'haf,
        8'h6d, 8'ha6, 8'h02, 8'hf1, 8'h07, 8'h4f, 8'he1, 8'h4a,
        8'hba, 8'h30, 8'h2f, 8'h12, 8'h56, 8'h8b, 8'h44, 8'h8d
    };

    // add key, substitute nibbles, rotate left
    function automatic logic [HalfW-1:0] round_f(input logic [HalfW-1:0] half,
                                                 input logic [HalfW-1:0] key);
        logic [HalfW-1:0] sum;
        logic [HalfW-1:0] sub;
        logic [3:0]       hi;
        logic [3:0]       lo;
        logic [7:0]       hb;
        logic [7:0]       lb;
        sum = half + key;
        sub = '0;
        for (int j = 0; j < 4; j++) begin
            hi = sum[8*j+4 +: 4];
            lo = sum[8*j +: 4];
            hb = SBOX[{hi, j[1:0]}];
            lb = SBOX[{lo, j[1:0]}];
            sub[8*j +: 8] = {hb[7:4], lb[3:0]};
        end
        return {sub[HalfW-RotAmt-1:0], sub[HalfW-1:HalfW-RotAmt]};
    endfunction

    // key schedule: 0..7 for the first 24 rounds, then 7..0
    function automatic logic [2:0] key_index(input int rnd);
        logic [2:0] r;
        r = rnd[2:0];
        return (rnd < EncFwdRounds) ? r : (3'd7 - r);
    endfunction

endpackage

/* design/gost_block_cipher_core.sv */
// GOST 28147-89 cipher core: 32 round cells in a chain, one block per cycle.
// Each block is registered in the 32 round cells in turn, then in the output
// register; MAC blocks pass through the last 16 cells.
// Throughput: one block per cycle, set by one round per cell; a stalled
// output fills a skid entry, after which the chain and the input freeze.
// Reset (synchronous, active low) clears the key words and all valid flags.
module gost_block_cipher_core
    import gbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // [31:0] half_a, [63:32] half_b
    input  logic        s_axis_tuser,   // [0] kind
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // [31:0] out_a, [63:32] out_b
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);

    t_key_words       w_keys;
    t_stage           w_stage [NumRounds+1];
    logic             w_en;
    logic [HalfW-1:0] w_out_a;
    logic [HalfW-1:0] w_out_b;
    t_stage           w_last;

    gbc_key_regs u_keys (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_keys  (w_keys)
    );

    assign s_axis_tready = w_en;

    // both modes start with the second half in u and the first in v
    assign w_stage[0] = '{valid: s_axis_tvalid,
                          kind:  s_axis_tuser,
                          u:     s_axis_tdata[63:32],
                          v:     s_axis_tdata[31:0]};

    for (genvar g = 0; g < NumRounds; g++) begin : g_cell
        localparam logic [2:0] KeyIdx = key_index(g);
        localparam logic       MacRound = (g < MacRounds);

        gbc_round_cell u_cell (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_en     (w_en),
            .i_active ((w_stage[g].kind == KIND_ENC) || MacRound),
            .i_key    (w_keys[KeyIdx]),
            .i_d      (w_stage[g]),
            .o_q      (w_stage[g+1])
        );
    end

    // encrypt ends with (a, b) in (u, v); MAC with (b, a)
    assign w_last  = w_stage[NumRounds];
    assign w_out_a = (w_last.kind == KIND_MAC) ? w_last.v : w_last.u;
    assign w_out_b = (w_last.kind == KIND_MAC) ? w_last.u : w_last.v;

    gbc_out_buf u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (w_last.valid),
        .i_data        ({w_out_b, w_out_a}),
        .o_en          (w_en),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

/* design/gbc_key_regs.sv */
// Key word registers behind the APB configuration port.
module gbc_key_regs
    import gbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    output t_key_words  o_keys
);

    logic [63:0] r_key01, r_key23, r_key45, r_key67;
    t_reg_idx    w_idx;
    logic        w_wr;

    assign w_idx  = t_reg_idx'(paddr[4:3]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key01 <= '0;
            r_key23 <= '0;
            r_key45 <= '0;
            r_key67 <= '0;
        end else if (w_wr) begin
            case (w_idx)
                REG_KEY01: r_key01 <= pwdata;
                REG_KEY23: r_key23 <= pwdata;
                REG_KEY45: r_key45 <= pwdata;
                REG_KEY67: r_key67 <= pwdata;
                default:   r_key01 <= r_key01;
            endcase
        end
    end

    always_comb begin
        case (w_idx)
            REG_KEY01: prdata = r_key01;
            REG_KEY23: prdata = r_key23;
            REG_KEY45: prdata = r_key45;
            REG_KEY67: prdata = r_key67;
            default:   prdata = '0;
        endcase
    end

    assign o_keys = {r_key67, r_key45, r_key23, r_key01};

endmodule

/* design/gbc_round_cell.sv */
// One Feistel round cell of the pipeline: round function and stage register.
module gbc_round_cell
    import gbc_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_active,
    input  logic [HalfW-1:0] i_key,
    input  t_stage           i_d,
    output t_stage           o_q
);

    logic             r_valid;
    logic             r_kind;
    logic [HalfW-1:0] r_u;
    logic [HalfW-1:0] r_v;
    logic [HalfW-1:0] n_u;
    logic [HalfW-1:0] n_v;

    always_comb begin
        if (i_active) begin
            n_u = i_d.v;
            n_v = i_d.u ^ round_f(i_d.v, i_key);
        end else begin
            n_u = i_d.u;
            n_v = i_d.v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_d.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_kind <= i_d.kind;
            r_u    <= n_u;
            r_v    <= n_v;
        end
    end

    assign o_q = '{valid: r_valid, kind: r_kind, u: r_u, v: r_v};

endmodule

/* design/gbc_out_buf.sv */
// Output register with skid entry; freezes the round pipeline when both are full.
module gbc_out_buf
    import gbc_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_valid,
    input  logic [63:0]  i_data,
    output logic         o_en,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [63:0]  m_axis_tdata
);

    logic        r_out_valid;
    logic [63:0] r_out_data;
    logic        r_skid_valid;
    logic [63:0] r_skid_data;
    logic        w_out_free;

    assign o_en          = !r_skid_valid;
    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (w_out_free) begin
            r_out_valid <= i_valid;
        end else if (i_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (m_axis_tready) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_out_free) begin
            r_out_data <= i_data;
        end else begin
            r_skid_data <= i_data;
        end
    end

endmodule

/* design/gbc_checker.sv */
// Port-level checks for the GOST cipher core, bound to the top level.
module gbc_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,
    input  logic        pready
);

    // a stalled result keeps its data
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // input is only held off while a result waits
    a_bp_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("input stalled with no result pending");

    // nothing comes out in the first cycle after reset
    a_rst_empty: assert property (@(posedge i_clk)
        i_rst_n && $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid straight after reset");

    // a result taken while the input is held off releases the input
    a_ready_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready && m_axis_tready |=> s_axis_tready)
        else $error("input still stalled after result transfer");

    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");

endmodule

bind gost_block_cipher_core gbc_checker u_gbc_checker (.*);

/* tb/sv/tb_top.sv */
// Self-checking testbench for the GOST block cipher core: stream traffic against a local predictor.
`timescale 1ns / 100ps

module tb_top;
    import gbc_pkg::*;

    typedef struct {
        logic [31:0] out_a;
        logic [31:0] out_b;
    } t_block;

    localparam logic [7:0] SUBST_TABLE [64] = '{
        8'hc4, 8'hed, 8'h83, 8'hc9, 8'h92, 8'h98, 8'hfe, 8'h6b,
        8'hff, 8'hbe, 8'h65, 8'h5c, 8'he5, 8'h2c, 8'hb9, 8'h20,
        8'h89, 8'h57, 8'h16, 8'hb3, 8'h11, 8'hf3, 8'h98, 8'h06,
        8'h30, 8'h79, 8'hc0, 8'h97, 8'ha8, 8'h1a, 8'h5d, 8'hd5,
        8'h2e, 8'h01, 8'hda, 8'h34, 8'h73, 8'hd5, 8'h3b, 8'he8,
        8'h4b, 8'hc2, 8'h77, 8'h7e, 8'hdc, 8'h64, 8'hac, 8'haf,
        8'h6d, 8'ha6, 8'h02, 8'hf1, 8'h07, 8'h4f, 8'he1, 8'h4a,
        8'hba, 8'h30, 8'h2f, 8'h12, 8'h56, 8'h8b, 8'h44, 8'h8d
    };

    localparam int PipeDrainCycles = 40;
    localparam int HoldOffCycles   = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata = '0;   // [31:0] half_a, [63:32] half_b
    logic        s_axis_tuser = 1'b0; // [0] kind
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;        // [31:0] out_a, [63:32] out_b
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    logic [31:0] key_sched [8];
    t_block      expected_blocks [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int err_count = 0;
    int results_checked = 0;
    int enc_sent = 0;
    int mac_sent = 0;
    int key_settings = 0;

    // output hold-off: the test flips hold_go, the receiver counts the stretch itself
    logic hold_go = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    gost_block_cipher_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ---------------- predictor ----------------

    function automatic logic [31:0] gost_round(input logic [31:0] half,
                                               input logic [31:0] key);
        logic [31:0] sum;
        logic [31:0] sub;
        logic [7:0]  hb;
        logic [7:0]  lb;
        int          j;
        sum = half + key;
        sub = '0;
        for (j = 0; j < 4; j++) begin
            hb = SUBST_TABLE[int'(sum[8*j+4 +: 4]) * 4 + j];
            lb = SUBST_TABLE[int'(sum[8*j +: 4]) * 4 + j];
            sub[8*j +: 8] = {hb[7:4], lb[3:0]};
        end
        return {sub[20:0], sub[31:21]};
    endfunction

    function automatic t_block cipher_block(input logic kind, input logic [31:0] a_in,
                                            input logic [31:0] b_in);
        logic [31:0] a;
        logic [31:0] b;
        t_block      res;
        int          p;
        int          r;
        if (kind == KIND_ENC) begin
            a = b_in;
            b = a_in;
            for (p = 0; p < 3; p++) begin
                for (r = 0; r < 8; r += 2) begin
                    a ^= gost_round(b, key_sched[r]);
                    b ^= gost_round(a, key_sched[r+1]);
                end
            end
            // last eight rounds walk the key words backwards
            for (r = 0; r < 8; r += 2) begin
                a ^= gost_round(b, key_sched[7-r]);
                b ^= gost_round(a, key_sched[6-r]);
            end
        end else begin
            a = a_in;
            b = b_in;
            for (p = 0; p < 2; p++) begin
                for (r = 0; r < 8; r += 2) begin
                    b ^= gost_round(a, key_sched[r]);
                    a ^= gost_round(b, key_sched[r+1]);
                end
            end
        end
        res.out_a = a;
        res.out_b = b;
        return res;
    endfunction

    // ---------------- shared tasks ----------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        err_count++;
        if (err_count <= 20)
            $display("tb_top: MISMATCH %s got %08h want %08h at %0t", what, got, want, $time);
    endtask

    // setup, access, then idle before returning so back-to-back writes never collide
    task automatic write_key_pair(input t_reg_idx idx, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        key_sched[2*int'(idx)]   = value[31:0];
        key_sched[2*int'(idx)+1] = value[63:32];
        @(posedge i_clk);
    endtask

    task automatic load_keys(input logic [63:0] k01, input logic [63:0] k23,
                             input logic [63:0] k45, input logic [63:0] k67);
        write_key_pair(REG_KEY01, k01);
        write_key_pair(REG_KEY23, k23);
        write_key_pair(REG_KEY45, k45);
        write_key_pair(REG_KEY67, k67);
        key_settings++;
    endtask

    // one block; returns at the edge where it was taken
    task automatic send_block(input logic kind, input logic [31:0] a, input logic [31:0] b);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {b, a};
        s_axis_tuser <= kind;
        do @(posedge i_clk); while (!s_axis_tready);
        expected_blocks.push_back(cipher_block(kind, a, b));
        if (kind == KIND_ENC)
            enc_sent++;
        else
            mac_sent++;
    endtask

    // sender goes quiet until every block has come back
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (expected_blocks.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_half();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'hffff_ffff;
            2: return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // ---------------- checking and receiver ----------------

    always @(posedge i_clk) begin
        t_block want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (expected_blocks.size() == 0) begin
                report_mismatch("unexpected result, out_a", m_axis_tdata[31:0], 32'h0);
            end else begin
                want = expected_blocks.pop_front();
                results_checked++;
                if (m_axis_tdata[31:0] !== want.out_a)
                    report_mismatch("out_a", m_axis_tdata[31:0], want.out_a);
                if (m_axis_tdata[63:32] !== want.out_b)
                    report_mismatch("out_b", m_axis_tdata[63:32], want.out_b);
            end
        end
    end

    always @(posedge i_clk) begin
        if (hold_go != hold_seen) begin
            hold_seen <= hold_go;
            hold_left <= HoldOffCycles;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ---------------- tests ----------------

    task automatic send_corner_blocks();
        send_block(KIND_ENC, 32'h0000_0000, 32'h0000_0000);
        send_block(KIND_MAC, 32'h0000_0000, 32'h0000_0000);
        send_block(KIND_ENC, 32'hffff_ffff, 32'hffff_ffff);
        send_block(KIND_MAC, 32'hffff_ffff, 32'hffff_ffff);
        send_block(KIND_ENC, 32'h8000_0000, 32'h0000_0001);
        send_block(KIND_MAC, 32'h0000_0001, 32'h8000_0000);
    endtask

    // keys straight out of reset are all zero
    task automatic test_reset_keys();
        key_settings++;
        send_corner_blocks();
        wait_drained();
    endtask

    // all-ones keys make every nonzero half+key sum wrap; then a mixed key set
    task automatic test_key_extremes();
        load_keys('1, '1, '1, '1);
        send_corner_blocks();
        wait_drained();
        load_keys(64'h5555_5555_aaaa_aaaa, 64'h0f0f_0f0f_f0f0_f0f0,
                  64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_block(KIND_ENC, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
        send_block(KIND_MAC, 32'h5a5a_5a5a, 32'ha5a5_a5a5);
        send_block(KIND_ENC, 32'h0123_4567, 32'h89ab_cdef);
        send_block(KIND_MAC, 32'hdead_beef, 32'h0000_ffff);
        wait_drained();
    endtask

    task automatic test_random_blocks(input int sender_pct, input int receiver_pct);
        int set_no;
        int n;
        send_idle_pct = sender_pct;
        recv_stall_pct = receiver_pct;
        for (set_no = 0; set_no < 2; set_no++) begin
            load_keys({$urandom, $urandom}, {$urandom, $urandom},
                      {$urandom, $urandom}, {$urandom, $urandom});
            for (n = 0; n < 170; n++)
                send_block(logic'($urandom_range(1)), pick_half(), pick_half());
            wait_drained();
        end
    endtask

    // long output stall with the sender pushing: pipeline and skid fill, input must freeze
    task automatic test_output_backpressure();
        int n;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_keys({$urandom, $urandom}, '0, {$urandom, $urandom}, '1);
        hold_go <= ~hold_go;
        for (n = 0; n < 80; n++)
            send_block(logic'($urandom_range(1)), $urandom, $urandom);
        wait_drained();
        recv_stall_pct = 20;
        for (n = 0; n < 20; n++)
            send_block(logic'($urandom_range(1)), $urandom, $urandom);
        wait_drained();
        load_keys('0, '0, '0, '0);
        send_block(KIND_ENC, 32'h1234_5678, 32'h9abc_def0);
        send_block(KIND_MAC, 32'h1234_5678, 32'h9abc_def0);
        wait_drained();
    endtask

    initial begin
        int k;
        for (k = 0; k < 8; k++)
            key_sched[k] = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        send_idle_pct = 35;
        recv_stall_pct = 63;
        test_reset_keys();
        test_key_extremes();
        test_random_blocks(35, 63);
        test_random_blocks(63, 35);
        test_random_blocks(0, 0);
        test_output_backpressure();
        repeat (PipeDrainCycles) @(posedge i_clk);
        $display("tb_top: %0d results checked (%0d encrypt, %0d MAC) under %0d key settings",
                 results_checked, enc_sent, mac_sent, key_settings);
        $display("tb_top: idle mixes 35/63, 63/35, none, plus a %0d-cycle output hold-off",
                 HoldOffCycles);
        if (err_count == 0 && expected_blocks.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb_top: timeout with %0d blocks outstanding", expected_blocks.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
